### rtl/core/cesd_pkg.sv
// ----------------------------------------------------------------------------
// cesd_pkg
// Types, character codes and helpers for the C string escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cesd_pkg;

  typedef enum logic [3:0] {
    M_TEXT = 4'b0001,
    M_ESC  = 4'b0010,
    M_OCT  = 4'b0100,
    M_HEX  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
  } result_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_F      = 8'h66;

  localparam logic [7:0] CTL_LF  = 8'd10;
  localparam logic [7:0] CTL_BEL = 8'd7;
  localparam logic [7:0] CTL_CR  = 8'd13;
  localparam logic [7:0] CTL_TAB = 8'd9;
  localparam logic [7:0] CTL_BS  = 8'd8;
  localparam logic [7:0] CTL_VT  = 8'd11;
  localparam logic [7:0] CTL_FF  = 8'd12;

  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

  function automatic logic is_oct(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h37);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd0;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      d = b - 8'h57;
      return {1'b1, d[3:0]};
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      d = b - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

`default_nettype wire

### rtl/core/cesd_in_if.sv
// ----------------------------------------------------------------------------
// cesd_in_if
// Raw character channel: one source byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cesd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

### rtl/core/cesd_out_if.sv
// ----------------------------------------------------------------------------
// cesd_out_if
// Decoded character channel: one decoded byte or end marker per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cesd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output byte_valid,
                  output run_last, output string_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input run_last, input string_end, output ready);
endinterface

`default_nettype wire

### rtl/core/c_escape_string_decoder.sv
// ----------------------------------------------------------------------------
// c_escape_string_decoder
// Decodes C string literal escapes from a byte stream.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   in_byte[7:0], in_last
//   out_ch   out  valid/ready   out_byte[7:0], byte_valid, run_last, string_end
//
// One input beat per cycle while the output keeps up; a beat that yields two
// bytes holds the input while the second byte drains from the result buffer.
// The first output beat is registered, in the cycle after its input beat.
// A stalled output keeps the current result; input is taken again once
// the buffer holds at most one result that leaves in the same cycle.
// rst (synchronous) returns the decoder to text mode and empties the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module c_escape_string_decoder
  import cesd_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  cesd_in_if.sink   in_ch,
  cesd_out_if.source out_ch
);

  mode_t      mode, mode_next;
  logic [7:0] accum, accum_next;
  logic [1:0] dcnt, dcnt_next;

  result_t    slot0, slot1;
  logic [1:0] cnt;

  logic [7:0] res_b [2];
  logic [1:0] n;
  logic       handle_text;
  logic [4:0] hx;
  logic [1:0] dcnt_inc;
  result_t    r0, r1;
  logic [1:0] n_out;
  logic       in_acc, out_acc;

  assign in_ch.ready = (cnt == 2'd0) || ((cnt == 2'd1) && out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  assign out_ch.valid      = (cnt != 2'd0);
  assign out_ch.out_byte   = slot0.out_byte;
  assign out_ch.byte_valid = slot0.byte_valid;
  assign out_ch.run_last   = slot0.run_last;
  assign out_ch.string_end = slot0.string_end;

  always_comb begin
    mode_next   = mode;
    accum_next  = accum;
    dcnt_next   = dcnt;
    n           = 2'd0;
    res_b[0]    = 8'd0;
    res_b[1]    = 8'd0;
    handle_text = 1'b0;
    hx          = hex_digit(in_ch.in_byte);
    dcnt_inc    = dcnt + 2'd1;

    unique case (mode)
      M_TEXT: begin
        handle_text = 1'b1;
      end
      M_ESC: begin
        mode_next = M_TEXT;
        case (in_ch.in_byte)
          CH_N: begin res_b[n[0]] = CTL_LF;  n = n + 2'd1; end
          CH_A: begin res_b[n[0]] = CTL_BEL; n = n + 2'd1; end
          CH_R: begin res_b[n[0]] = CTL_CR;  n = n + 2'd1; end
          CH_T: begin res_b[n[0]] = CTL_TAB; n = n + 2'd1; end
          CH_B: begin res_b[n[0]] = CTL_BS;  n = n + 2'd1; end
          CH_V: begin res_b[n[0]] = CTL_VT;  n = n + 2'd1; end
          CH_F: begin res_b[n[0]] = CTL_FF;  n = n + 2'd1; end
          CH_X: begin
            mode_next  = M_HEX;
            accum_next = 8'd0;
            dcnt_next  = 2'd0;
          end
          default: begin
            if (is_oct(in_ch.in_byte)) begin
              mode_next  = M_OCT;
              accum_next = {5'd0, in_ch.in_byte[2:0]};
              dcnt_next  = 2'd1;
            end else begin
              res_b[n[0]] = in_ch.in_byte;
              n           = n + 2'd1;
            end
          end
        endcase
      end
      M_OCT: begin
        if (is_oct(in_ch.in_byte)) begin
          accum_next = {accum[4:0], in_ch.in_byte[2:0]};
          dcnt_next  = dcnt_inc;
          if (dcnt_inc == OCT_MAX_DIGITS) begin
            res_b[n[0]] = accum_next;
            n           = n + 2'd1;
            mode_next   = M_TEXT;
            accum_next  = 8'd0;
            dcnt_next   = 2'd0;
          end
        end else begin
          res_b[n[0]] = accum;
          n           = n + 2'd1;
          mode_next   = M_TEXT;
          accum_next  = 8'd0;
          dcnt_next   = 2'd0;
          handle_text = 1'b1;
        end
      end
      M_HEX: begin
        if (hx[4]) begin
          accum_next = {accum[3:0], hx[3:0]};
          dcnt_next  = 2'd1;
        end else begin
          if (dcnt != 2'd0) begin
            res_b[n[0]] = accum;
            n           = n + 2'd1;
          end
          mode_next   = M_TEXT;
          accum_next  = 8'd0;
          dcnt_next   = 2'd0;
          handle_text = 1'b1;
        end
      end
      default: begin
        mode_next  = M_TEXT;
        accum_next = 8'd0;
        dcnt_next  = 2'd0;
      end
    endcase

    if (handle_text) begin
      if (in_ch.in_byte == CH_BSLASH) begin
        mode_next = M_ESC;
      end else begin
        res_b[n[0]] = in_ch.in_byte;
        n           = n + 2'd1;
      end
    end

    // end of string: flush pending escape value
    if (in_ch.in_last) begin
      if ((mode_next == M_OCT) || ((mode_next == M_HEX) && (dcnt_next != 2'd0))) begin
        res_b[n[0]] = accum_next;
        n           = n + 2'd1;
      end
      mode_next  = M_TEXT;
      accum_next = 8'd0;
      dcnt_next  = 2'd0;
    end

    r0.out_byte   = res_b[0];
    r0.byte_valid = 1'b1;
    r0.run_last   = (n == 2'd1);
    r0.string_end = in_ch.in_last && (n == 2'd1);
    r1.out_byte   = res_b[1];
    r1.byte_valid = 1'b1;
    r1.run_last   = 1'b1;
    r1.string_end = in_ch.in_last;
    n_out         = n;

    if (in_ch.in_last && (n == 2'd0)) begin
      r0.out_byte   = 8'd0;
      r0.byte_valid = 1'b0;
      r0.run_last   = 1'b1;
      r0.string_end = 1'b1;
      n_out         = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_TEXT;
      accum <= 8'd0;
      dcnt  <= 2'd0;
      cnt   <= 2'd0;
    end else begin
      if (in_acc) begin
        mode  <= mode_next;
        accum <= accum_next;
        dcnt  <= dcnt_next;
        slot0 <= r0;
        slot1 <= r1;
        cnt   <= n_out;
      end else if (out_acc) begin
        if (cnt == 2'd2) begin
          slot0 <= slot1;
          cnt   <= 2'd1;
        end else begin
          cnt <= 2'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/cesd_checker.sv
// ----------------------------------------------------------------------------
// cesd_checker
// Port-level checks for the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cesd_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire       byte_valid,
  input wire       run_last,
  input wire       string_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid))
    else $error("output beat changed while stalled");

  a_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> run_last && string_end && (out_byte == 8'd0))
    else $error("end marker malformed");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_last)
    else $error("string end without run end");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("buffer not empty after reset");

  a_input_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !run_last |-> !in_ready)
    else $error("input taken while second result pending");

endmodule

bind c_escape_string_decoder cesd_checker u_cesd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .byte_valid (out_ch.byte_valid),
  .run_last   (out_ch.run_last),
  .string_end (out_ch.string_end)
);

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the C string escape decoder. Raw literal bytes are
// driven on the input channel and every decoded beat is checked against a
// behavioral decoder kept in the bench: directed strings for each escape kind
// and string-end case, then random token strings under several idle/stall
// mixes on both channels.
// ----------------------------------------------------------------------------

module tb;
  import cesd_pkg::*;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_7  = 8'h37;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst = 1'b1;

  cesd_in_if  in_ch ();
  cesd_out_if out_ch ();

  c_escape_string_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // decoder state mirrored by the bench
  mode_t      esc_mode;
  logic [7:0] esc_acc;
  logic [1:0] esc_digits;

  result_t    decoded_q[$];
  logic [7:0] lit_q[$];
  logic [7:0] ctl_keys [7] = '{CH_N, CH_A, CH_R, CH_T, CH_B, CH_V, CH_F};
  string      hex_chars = "0123456789abcdefABCDEF";

  int src_idle = 0;
  int snk_stall = 0;
  int n_err = 0;
  int n_in = 0;
  int n_out = 0;
  int n_strings = 0;
  int n_pairs = 0;
  int n_marks = 0;
  int quiet = 0;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_A && c <= CH_F) return int'(c - CH_A) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  task automatic drop_escape();
    esc_mode = M_TEXT;
    esc_acc = 8'd0;
    esc_digits = 2'd0;
  endtask

  task automatic decode_beat(input logic [7:0] c, input logic fin);
    logic [7:0] got[$];
    int hv;
    logic as_txt;
    result_t r;
    as_txt = 1'b0;
    case (esc_mode)
      M_TEXT: as_txt = 1'b1;
      M_ESC: begin
        esc_mode = M_TEXT;
        case (c)
          CH_N: got.push_back(CTL_LF);
          CH_A: got.push_back(CTL_BEL);
          CH_R: got.push_back(CTL_CR);
          CH_T: got.push_back(CTL_TAB);
          CH_B: got.push_back(CTL_BS);
          CH_V: got.push_back(CTL_VT);
          CH_F: got.push_back(CTL_FF);
          CH_X: begin
            esc_mode = M_HEX;
            esc_acc = 8'd0;
            esc_digits = 2'd0;
          end
          default: begin
            if (c >= CH_0 && c <= CH_7) begin
              esc_mode = M_OCT;
              esc_acc = c - CH_0;
              esc_digits = 2'd1;
            end else begin
              got.push_back(c);
            end
          end
        endcase
      end
      M_OCT: begin
        if (c >= CH_0 && c <= CH_7) begin
          esc_acc = {esc_acc[4:0], c[2:0]};
          esc_digits = esc_digits + 2'd1;
          if (esc_digits == OCT_MAX_DIGITS) begin
            got.push_back(esc_acc);
            drop_escape();
          end
        end else begin
          got.push_back(esc_acc);
          drop_escape();
          as_txt = 1'b1;
        end
      end
      default: begin
        hv = hex_nibble(c);
        if (hv >= 0) begin
          esc_acc = {esc_acc[3:0], 4'(hv)};
          esc_digits = 2'd1;
        end else begin
          if (esc_digits != 2'd0) got.push_back(esc_acc);
          drop_escape();
          as_txt = 1'b1;
        end
      end
    endcase
    if (as_txt) begin
      if (c == CH_BSLASH) esc_mode = M_ESC;
      else got.push_back(c);
    end
    if (fin) begin
      if (esc_mode == M_OCT || (esc_mode == M_HEX && esc_digits != 2'd0))
        got.push_back(esc_acc);
      drop_escape();
      if (got.size() == 0) begin
        r.out_byte = 8'd0;
        r.byte_valid = 1'b0;
        r.run_last = 1'b1;
        r.string_end = 1'b1;
        decoded_q.push_back(r);
        n_marks++;
      end
    end
    if (got.size() == 2) n_pairs++;
    foreach (got[k]) begin
      r.out_byte = got[k];
      r.byte_valid = 1'b1;
      r.run_last = (k == got.size() - 1);
      r.string_end = fin && (k == got.size() - 1);
      decoded_q.push_back(r);
    end
  endtask

  // called and returns at a falling edge
  task automatic send_beat(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid = 1'b0;
      in_ch.in_byte = 8'($urandom);
      in_ch.in_last = 1'($urandom);
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.in_byte = c;
    in_ch.in_last = fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_beat(c, fin);
    n_in++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], fin && (i == s.len() - 1));
    end
    if (fin) n_strings++;
  endtask

  task automatic test_text_controls();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text("\\n\\a\\r\\t\\b\\v\\f", 1'b1);
  endtask

  // full three digits with truncation, early stop by text, flush at end
  task automatic test_octal();
    send_text("\\777\\12z\\5", 1'b1);
  endtask

  // digits of both cases, stop by text, no digits, long run flushed at end
  task automatic test_hex();
    send_text("\\x4Fg\\xq\\xaB1", 1'b1);
  endtask

  // dangling backslash, bare x, escaped backslash as last byte
  task automatic test_string_end();
    send_text("\\", 1'b1);
    send_text("\\x", 1'b1);
    send_text("\\\\", 1'b1);
  endtask

  task automatic add_token();
    int pick;
    int k;
    pick = $urandom_range(99);
    if (pick < 35) begin
      lit_q.push_back(8'($urandom_range(255)));
    end else if (pick < 50) begin
      lit_q.push_back(CH_BSLASH);
      lit_q.push_back(ctl_keys[$urandom_range(6)]);
    end else if (pick < 65) begin
      lit_q.push_back(CH_BSLASH);
      k = $urandom_range(1, 3);
      repeat (k) lit_q.push_back(CH_0 + 8'($urandom_range(7)));
    end else if (pick < 80) begin
      lit_q.push_back(CH_BSLASH);
      lit_q.push_back(CH_X);
      k = $urandom_range(0, 4);
      repeat (k) lit_q.push_back(hex_chars[$urandom_range(21)]);
    end else if (pick < 92) begin
      lit_q.push_back(CH_BSLASH);
      lit_q.push_back(8'($urandom_range(255)));
    end else begin
      lit_q.push_back(CH_BSLASH);
    end
  endtask

  task automatic test_random_strings(input int count, input int idle, input int stall);
    int sent;
    sent = 0;
    src_idle = idle;
    snk_stall = stall;
    while (sent < count) begin
      lit_q.delete();
      repeat ($urandom_range(1, 8)) add_token();
      foreach (lit_q[i]) send_beat(lit_q[i], i == lit_q.size() - 1);
      sent += lit_q.size();
      n_strings++;
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= snk_stall);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_out++;
      if (decoded_q.size() == 0) begin
        $error("unexpected beat: out_byte %0h byte_valid %0b", out_ch.out_byte,
               out_ch.byte_valid);
        n_err++;
      end else begin
        want = decoded_q.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_ch.out_byte);
          n_err++;
        end
        if (out_ch.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid,
                 out_ch.byte_valid);
          n_err++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_ch.run_last);
          n_err++;
        end
        if (out_ch.string_end !== want.string_end) begin
          $error("string_end: expected %0b, got %0b", want.string_end,
                 out_ch.string_end);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (!in_ch.valid && decoded_q.size() == 0)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet + 1 >= QUIET_LIMIT) begin
        $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'd0;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    drop_escape();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_text_controls();
    test_octal();
    test_hex();
    test_string_end();
    test_random_strings(125, 0, 0);
    test_random_strings(125, 52, 0);
    test_random_strings(125, 0, 52);
    test_random_strings(125, 38, 38);
    in_ch.valid = 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d strings, %0d input beats, %0d decoded beats checked", n_strings, n_in,
             n_out);
    $display("%0d inputs gave two bytes, %0d strings ended with an empty marker", n_pairs,
             n_marks);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_err);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
